// ===== hw/rtl/bss_pkg.sv =====
package bss_pkg;

   // Operation codes carried in the request's tuser field.
   typedef enum logic [2:0] {
      MODE_INSERT  = 3'd0,
      MODE_REMOVE  = 3'd1,
      MODE_LOOKUP  = 3'd2,
      MODE_GET     = 3'd3,
      MODE_REPLACE = 3'd4
   } mode_type;

   // What a cell does with its entry at the next clock edge.
   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_WRITE,
      ACT_SHIFT
   } cell_action_type;

   // Command broadcast along the row of cells.
   typedef struct packed {
      cell_action_type    action;
      logic signed [31:0] key;
   } cell_cmd_type;

   // Field widths of the streaming ports.
   localparam int VALUE_W = 32;
   localparam int POS_W   = 6;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;

endpackage

// ===== hw/rtl/bss_cell.sv =====
module bss_cell #(
   parameter int CELL_INDEX = 0,
   parameter int IDX_W      = 6,
   parameter int CNT_W      = 7
) (
   input  logic                clock,
   input  bss_pkg::cell_cmd_type cmd,
   input  logic [IDX_W-1:0]    target,
   input  logic [CNT_W-1:0]    size,
   input  logic signed [31:0]  next_entry,
   output logic signed [31:0]  entry,
   output logic                match,
   output logic signed [31:0]  read_data
);
   import bss_pkg::*;

   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);
   localparam logic [CNT_W-1:0] MY_COUNT = CNT_W'(CELL_INDEX);

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;
   logic               occupied;

   // Only slots below the fill level take part in a search.
   assign occupied  = MY_COUNT < size;
   assign match     = occupied && (entry_ff == cmd.key);
   assign read_data = (target == MY_INDEX) ? entry_ff : '0;
   assign entry     = entry_ff;

   // Write at the target slot, or take the upper neighbour's entry when a
   // removal closes the gap at or below this slot.
   always_comb begin
      entry_in = entry_ff;
      case (cmd.action)
         ACT_WRITE: begin
            if (target == MY_INDEX) begin
               entry_in = cmd.key;
            end
         end
         ACT_SHIFT: begin
            if (MY_INDEX >= target) begin
               entry_in = next_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hw/rtl/bounded_set_store_unit.sv =====
// Bounded set store: a set of distinct signed 32-bit values kept packed in
// insertion order in a row of CAPACITY cells.
// Request channel (req_): tuser carries the operation (insert, remove,
// lookup, get, replace); tdata carries the value and the slot position.
// Response channel (rsp_): one response per request, giving the success
// flag, the slot where the value was found, the element read by a get and
// the element count after the request.
// The response is registered. Each request makes a search, a match-resolve
// and an update step over the cell row, and a new request is taken only
// once the last one has left the update step.
// A new request is taken while an earlier response still waits; the update
// step then waits until the response register is free.
// Reset empties the set at once; entry contents are not cleared, as slots
// beyond the fill level are never reported.
module bounded_set_store_unit #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value [31:0], position [37:32], zero pad
   input  logic [2:0]  req_tuser,   // mode [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // ok [0], slot [6:1], element [38:7],
                                    // count [45:39], zero pad
);
   import bss_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int PW    = (IDX_W > POS_W) ? IDX_W : POS_W;
   localparam int SW    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int AW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_RESOLVE,
      S_APPLY
   } state_type;

   state_type                 state_ff;
   logic [2:0]                mode_ff;
   logic signed [31:0]        value_ff;
   logic [POS_W-1:0]          pos_ff;
   logic [CNT_W-1:0]          size_ff;
   logic [CNT_W-1:0]          size_in;
   logic [CAPACITY-1:0]       match_ff;
   logic signed [31:0]        read_ff;
   logic                      found_ff;
   logic [IDX_W-1:0]          at_ff;
   logic                      rsp_valid_ff;
   logic [47:0]               rsp_data_ff;

   logic [CAPACITY-1:0]       match_vec;
   logic signed [31:0]        cell_entry [CAPACITY];
   logic signed [31:0]        cell_read  [CAPACITY];
   logic signed [31:0]        read_or;
   logic [IDX_W-1:0]          at_or;
   cell_cmd_type              cmd;
   logic [IDX_W-1:0]          target;
   logic [PW-1:0]             pos_wide;
   logic [SW-1:0]             pos_cmp;
   logic [SW-1:0]             size_cmp;
   logic                      pos_in_cap;
   logic                      apply_go;
   logic                      ok;
   logic [IDX_W-1:0]          slot_idx;
   logic signed [31:0]        element;
   logic [CW-1:0]             count_wide;
   logic [AW-1:0]             slot_wide;

   assign pos_wide   = PW'(pos_ff);
   assign pos_cmp    = SW'(pos_ff);
   assign size_cmp   = SW'(size_ff);
   assign pos_in_cap = 32'(pos_ff) < CAPACITY;
   assign apply_go   = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_tready);

   // Row of cells; each hands its entry down to the slot below on a removal.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] next_entry;
      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = cell_entry[i];
      end else begin : g_mid
         assign next_entry = cell_entry[i+1];
      end
      bss_cell #(
         .CELL_INDEX (i),
         .IDX_W      (IDX_W),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .target     (target),
         .size       (size_ff),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .match      (match_vec[i]),
         .read_data  (cell_read[i])
      );
   end

   // Combine per-cell results; stored values are distinct, so at most one
   // cell matches and an OR of the indices gives the slot.
   always_comb begin
      read_or = '0;
      at_or   = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_or = read_or | cell_read[i];
         at_or   = at_or | (match_ff[i] ? IDX_W'(i) : '0);
      end
   end

   // Decide the update and the response for the request in hand.
   always_comb begin
      cmd.key    = value_ff;
      cmd.action = ACT_HOLD;
      target     = pos_wide[IDX_W-1:0];
      size_in    = size_ff;
      ok         = 1'b0;
      slot_idx   = '0;
      element    = '0;
      case (mode_ff)
         MODE_INSERT: begin
            if (found_ff) begin
               slot_idx = at_ff;
            end else if (size_ff < CAP_COUNT) begin
               cmd.action = ACT_WRITE;
               target     = size_ff[IDX_W-1:0];
               size_in    = size_ff + 1'b1;
               ok         = 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (found_ff) begin
               slot_idx   = at_ff;
               cmd.action = ACT_SHIFT;
               target     = at_ff;
               size_in    = size_ff - 1'b1;
               ok         = 1'b1;
            end
         end
         MODE_LOOKUP: begin
            if (found_ff) begin
               slot_idx = at_ff;
               ok       = 1'b1;
            end
         end
         MODE_GET: begin
            if (pos_cmp < size_cmp && pos_in_cap) begin
               element = read_ff;
               ok      = 1'b1;
            end
         end
         MODE_REPLACE: begin
            if (found_ff) begin
               slot_idx = at_ff;
            end else if (pos_cmp <= size_cmp && pos_in_cap) begin
               cmd.action = ACT_WRITE;
               ok         = 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      if (!apply_go) begin
         cmd.action = ACT_HOLD;
         size_in    = size_ff;
      end
   end

   assign count_wide = CW'(size_in);
   assign slot_wide  = AW'(slot_idx);

   // Request sequencing, fill level and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !apply_go) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               state_ff <= S_RESOLVE;
            end
            S_RESOLVE: begin
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (apply_go) begin
                  size_ff      <= size_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Payload registers along the sequence.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         mode_ff  <= req_tuser;
         value_ff <= req_tdata[31:0];
         pos_ff   <= req_tdata[37:32];
      end
      if (state_ff == S_SEARCH) begin
         match_ff <= match_vec;
         read_ff  <= read_or;
      end
      if (state_ff == S_RESOLVE) begin
         found_ff <= |match_ff;
         at_ff    <= at_or;
      end
      if (apply_go) begin
         rsp_data_ff <= {2'b00, count_wide[COUNT_W-1:0], element,
                         slot_wide[SLOT_W-1:0], ok};
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The fill level never passes the capacity.
   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      size_ff <= CAP_COUNT)
      else $error("fill level above capacity");

   // Stored values are distinct, so a search hits at most one cell.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESOLVE |-> $onehot0(match_ff))
      else $error("more than one cell matched");

   // A response appears only out of the update step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_APPLY))
      else $error("response raised outside the update step");

   // The fill level moves only in the update step.
   a_size_change: assert property (@(posedge clock) disable iff (reset)
      !$stable(size_ff) && !$past(reset) |-> $past(apply_go))
      else $error("fill level changed outside the update step");

endmodule
